// ===== hdl/s256pre_pkg.sv =====
// Shared types, round constants and SHA-256 round functions for the
// three-round midstate precompute block. No dependencies.
package s256pre_pkg;

  localparam int unsigned ROUNDS = 3;
  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Round constants K0..K2, index 0 in the lowest word
  localparam logic [ROUNDS-1:0][WORD_W-1:0] ROUND_K = {
    32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  // Everything one item carries down the pipeline
  typedef struct packed {
    logic [ROUNDS-1:0][WORD_W-1:0] res_e;
    logic [ROUNDS-1:0][WORD_W-1:0] res_a;
    logic [ROUNDS-1:0][WORD_W-1:0] w;
    word_t h;
    word_t g;
    word_t f;
    word_t e;
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } pipe_t;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) | (c & (a | b));
  endfunction

endpackage

// ===== hdl/sha256_three_round_precalc.sv =====
// Top level of the SHA-256 three-round midstate precompute.
// Depends on s256pre_pkg and s256pre_round.
//
// Usage:
//   Input stream (in_*): one transfer carries the midstate words a..h and
//   message words W0..W2 of the second block. Output stream (out_*): one
//   transfer per input carries working variables a and e after each of the
//   first three rounds.
//   Stages: one round per register stage; the third stage register is the
//   output register.
//   Throughput: one item per cycle while out_tready is high; each of the
//   three round stages holds one item, so three items can be in flight.
//   Reset: rst_n (synchronous, active low) clears the stage valid bits; any
//   items in flight are dropped and out_tvalid falls.
//   Stall: when out_tready is low the result holds on out_tdata. Stages
//   behind it keep filling bubbles, so in_tready stays high until every
//   stage holds an item; no item is lost or repeated.
module sha256_three_round_precalc (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h, msg_w0, msg_w1, msg_w2
  input  logic [351:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // a_round0, a_round1, a_round2, e_round0, e_round1, e_round2
  output logic [191:0] out_tdata
);

  localparam int unsigned NSTG = s256pre_pkg::ROUNDS;

  s256pre_pkg::pipe_t stg_data  [NSTG+1];
  logic               stg_valid [NSTG+1];
  logic               stg_ready [NSTG+1];

  // unpack the input transfer
  always_comb begin
    stg_data[0]       = '0;
    stg_data[0].a     = in_tdata[31:0];
    stg_data[0].b     = in_tdata[63:32];
    stg_data[0].c     = in_tdata[95:64];
    stg_data[0].d     = in_tdata[127:96];
    stg_data[0].e     = in_tdata[159:128];
    stg_data[0].f     = in_tdata[191:160];
    stg_data[0].g     = in_tdata[223:192];
    stg_data[0].h     = in_tdata[255:224];
    stg_data[0].w[0]  = in_tdata[287:256];
    stg_data[0].w[1]  = in_tdata[319:288];
    stg_data[0].w[2]  = in_tdata[351:320];
  end

  assign stg_valid[0] = in_tvalid;
  assign in_tready    = stg_ready[0];

  // one stage per round
  for (genvar r = 0; r < NSTG; r++) begin : g_round
    s256pre_round #(
      .ROUND(r)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[r]),
      .up_ready (stg_ready[r]),
      .up_data  (stg_data[r]),
      .dn_valid (stg_valid[r+1]),
      .dn_ready (stg_ready[r+1]),
      .dn_data  (stg_data[r+1])
    );
  end

  // pack the result transfer
  assign out_tvalid      = stg_valid[NSTG];
  assign stg_ready[NSTG] = out_tready;
  assign out_tdata = {stg_data[NSTG].res_e[2], stg_data[NSTG].res_e[1],
                      stg_data[NSTG].res_e[0], stg_data[NSTG].res_a[2],
                      stg_data[NSTG].res_a[1], stg_data[NSTG].res_a[0]};

endmodule

// ===== hdl/s256pre_round.sv =====
// One SHA-256 compression round as a registered pipeline stage with
// valid/ready flow control. Depends on s256pre_pkg.
module s256pre_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  s256pre_pkg::pipe_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output s256pre_pkg::pipe_t dn_data
);

  logic               vld_r;
  s256pre_pkg::pipe_t data_r;
  s256pre_pkg::pipe_t data_nxt;
  logic               load;
  s256pre_pkg::word_t t1;
  s256pre_pkg::word_t t2;

  // stage takes a new item when empty or when its item leaves this cycle
  assign load     = !vld_r || dn_ready;
  assign up_ready = load;

  // round datapath
  always_comb begin
    t1 = up_data.h + s256pre_pkg::big_sigma1(up_data.e)
       + s256pre_pkg::choose(up_data.e, up_data.f, up_data.g)
       + s256pre_pkg::ROUND_K[ROUND] + up_data.w[ROUND];
    t2 = s256pre_pkg::big_sigma0(up_data.a)
       + s256pre_pkg::majority(up_data.a, up_data.b, up_data.c);
    data_nxt = up_data;
    data_nxt.h = up_data.g;
    data_nxt.g = up_data.f;
    data_nxt.f = up_data.e;
    data_nxt.e = up_data.d + t1;
    data_nxt.d = up_data.c;
    data_nxt.c = up_data.b;
    data_nxt.b = up_data.a;
    data_nxt.a = t1 + t2;
    data_nxt.res_a[ROUND] = t1 + t2;
    data_nxt.res_e[ROUND] = up_data.d + t1;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= up_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

// ===== tb/tb_sha256_three_round_precalc.sv =====
// Self-checking testbench for the SHA-256 three-round midstate precompute.
// Depends on s256pre_pkg (word type) and the sha256_three_round_precalc RTL.
module tb_sha256_three_round_precalc;
  timeunit 1ns;
  timeprecision 1ps;

  typedef s256pre_pkg::word_t word_t;

  localparam int unsigned N_FIELDS_IN = 11;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 12;

  // SHA-256 round constants for rounds 0..2, round 0 in the lowest word
  localparam logic [2:0][31:0] SHA_K = {32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  // Input transfer, mid_a in the lowest bits
  typedef struct packed {
    word_t msg_w2;
    word_t msg_w1;
    word_t msg_w0;
    word_t mid_h;
    word_t mid_g;
    word_t mid_f;
    word_t mid_e;
    word_t mid_d;
    word_t mid_c;
    word_t mid_b;
    word_t mid_a;
  } midstate_item_t;

  // Result transfer, a_round0 in the lowest bits
  typedef struct packed {
    word_t e_round2;
    word_t e_round1;
    word_t e_round0;
    word_t a_round2;
    word_t a_round1;
    word_t a_round0;
  } round_words_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [351:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;

  // Idling control: when set, that side never idles
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  round_words_t rounds_q[$];
  int unsigned  n_sent = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_errors = 0;
  int unsigned  idle_cycles = 0;

  always #1 clk = ~clk;

  sha256_three_round_precalc u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Three compression rounds on the midstate, keeping new a and new e
  function automatic round_words_t calc_rounds(input midstate_item_t it);
    word_t        a, b, c, d, e, f, g, h;
    word_t        t1, t2, ch, mj;
    word_t        msg [3];
    word_t        new_a [3];
    word_t        new_e [3];
    round_words_t res;
    a = it.mid_a; b = it.mid_b; c = it.mid_c; d = it.mid_d;
    e = it.mid_e; f = it.mid_f; g = it.mid_g; h = it.mid_h;
    msg[0] = it.msg_w0;
    msg[1] = it.msg_w1;
    msg[2] = it.msg_w2;
    for (int r = 0; r < 3; r++) begin
      ch = (e & f) ^ (~e & g);
      mj = (a & b) ^ (a & c) ^ (b & c);
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + SHA_K[r] + msg[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
      h = g; g = f; f = e;
      e = d + t1;
      d = c; c = b; b = a;
      a = t1 + t2;
      new_a[r] = a;
      new_e[r] = e;
    end
    res.a_round0 = new_a[0];
    res.a_round1 = new_a[1];
    res.a_round2 = new_a[2];
    res.e_round0 = new_e[0];
    res.e_round1 = new_e[1];
    res.e_round2 = new_e[2];
    return res;
  endfunction

  task automatic check_field(input string name, input word_t exp_w, input word_t act_w);
    if (exp_w !== act_w) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("Mismatch on result %0d, %s: expected %08h, got %08h",
                 n_checked, name, exp_w, act_w);
    end
  endtask

  // Handshakes are sampled at the falling edge, where nothing is changing;
  // a transfer seen here completes at the following rising edge.
  always @(negedge clk) begin
    round_words_t exp_r;
    round_words_t act_r;
    if (rst_n && in_tvalid && in_tready) begin
      rounds_q.push_back(calc_rounds(midstate_item_t'(in_tdata)));
      n_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      act_r = round_words_t'(out_tdata);
      if (rounds_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("Unexpected result transfer: %048h", out_tdata);
      end else begin
        exp_r = rounds_q.pop_front();
        check_field("a_round0", exp_r.a_round0, act_r.a_round0);
        check_field("a_round1", exp_r.a_round1, act_r.a_round1);
        check_field("a_round2", exp_r.a_round2, act_r.a_round2);
        check_field("e_round0", exp_r.e_round0, act_r.e_round0);
        check_field("e_round1", exp_r.e_round1, act_r.e_round1);
        check_field("e_round2", exp_r.e_round2, act_r.e_round2);
        n_checked++;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("[sha256_three_round_precalc] ERROR");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Entered and left just after a rising edge; may idle first
  task automatic send_item(input midstate_item_t it);
    if (!tx_steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
  endtask

  // Hold the input off until every outstanding result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (rounds_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Word generator biased towards carry and rotate corners
  function automatic word_t corner_word();
    word_t one_bit;
    one_bit = 32'h1 << $urandom_range(31);
    case ($urandom_range(11))
      0:       return '0;
      1:       return '1;
      2:       return one_bit;
      3:       return ~one_bit;
      4:       return 32'h8000_0000 - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic midstate_item_t random_item(input bit corners);
    midstate_item_t it;
    for (int f = 0; f < N_FIELDS_IN; f++)
      it[f*32 +: 32] = corners ? corner_word() : word_t'($urandom);
    return it;
  endfunction

  // Field extremes, standard IV and wrap-around cases
  task automatic test_directed();
    midstate_item_t it;
    it = '0;
    send_item(it);
    it = '1;
    send_item(it);
    it = {N_FIELDS_IN{32'haaaa_aaaa}};
    send_item(it);
    it = {N_FIELDS_IN{32'h5555_5555}};
    send_item(it);
    // each field alone at all ones
    for (int f = 0; f < N_FIELDS_IN; f++) begin
      it = '0;
      it[f*32 +: 32] = '1;
      send_item(it);
    end
    // standard initial hash value as midstate with a padded message
    it.mid_a = 32'h6a09e667; it.mid_b = 32'hbb67ae85;
    it.mid_c = 32'h3c6ef372; it.mid_d = 32'ha54ff53a;
    it.mid_e = 32'h510e527f; it.mid_f = 32'h9b05688c;
    it.mid_g = 32'h1f83d9ab; it.mid_h = 32'h5be0cd19;
    it.msg_w0 = 32'h6162_6380; it.msg_w1 = '0; it.msg_w2 = '0;
    send_item(it);
    // sums that wrap several times round 2^32
    it = '1;
    it.mid_e = 32'h0000_0000;
    send_item(it);
    it = {N_FIELDS_IN{32'h8000_0001}};
    send_item(it);
    it = {N_FIELDS_IN{32'hdead_beef}};
    it.msg_w0 = 32'hdec8_1179; // cancels K0 plus h
    send_item(it);
    wait_results_drained();
  endtask

  task automatic test_random_idling(input int unsigned count);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    for (int unsigned i = 0; i < count; i++)
      send_item(random_item($urandom_range(1) != 0));
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back(input int unsigned count);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int unsigned i = 0; i < count; i++)
      send_item(random_item($urandom_range(1) != 0));
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Short bursts, each followed by a full drain of the pipeline
  task automatic test_drained_bursts(input int unsigned bursts);
    for (int unsigned b = 0; b < bursts; b++) begin
      repeat ($urandom_range(1, 6)) send_item(random_item(1'b1));
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_idling(350);
    test_back_to_back(250);
    test_drained_bursts(14);
    test_random_idling(180);

    in_tvalid <= 1'b0;
    while (rounds_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d midstates: corner words, random words, back-to-back and drained bursts",
             n_sent);
    $display("with random back-pressure; %0d results compared field by field.", n_checked);
    if (n_errors == 0 && rounds_q.size() == 0) begin
      $display("[sha256_three_round_precalc] OK");
    end else begin
      $display("%0d errors", n_errors);
      $display("[sha256_three_round_precalc] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/s256pre_pkg.sv
hdl/s256pre_round.sv
hdl/sha256_three_round_precalc.sv
tb/tb_sha256_three_round_precalc.sv
